// ===== design/cdr_pkg.sv =====
// ----------------------------------------------------------------------------
// cdr_pkg
// Types, register numbers and constants of the coprocessor control registers.
// ----------------------------------------------------------------------------
package cdr_pkg;

  // field widths
  localparam int unsigned REG_W     = 5;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned LOCAL_W   = 13;
  localparam int unsigned REMOTE_W  = 24;
  localparam int unsigned LEN_W     = 13;
  localparam int unsigned ROWS_W    = 9;
  localparam int unsigned SKIP_W    = 12;
  localparam int unsigned STATUS_W  = 15;
  localparam int unsigned DISP_W    = 8;
  localparam int unsigned PROD_W    = LEN_W + ROWS_W;

  // reset values and fixed sizes
  localparam logic [STATUS_W-1:0] STATUS_RESET = 15'h0001;
  localparam logic [DISP_W-1:0]   DISP_RESET   = 8'h80;
  localparam logic [LEN_W-1:0]    BANK_SIZE    = 13'h1000;
  localparam logic [LEN_W-1:0]    DMA_MIN_LEN  = 13'd8;

  // access kinds
  localparam logic ACT_WRITE    = 1'b0;
  localparam logic ACT_SEM_READ = 1'b1;

  // register numbers
  localparam logic [REG_W-1:0] REG_LOCAL_ADDR  = 5'd0;
  localparam logic [REG_W-1:0] REG_REMOTE_ADDR = 5'd1;
  localparam logic [REG_W-1:0] REG_DMA_READ    = 5'd2;
  localparam logic [REG_W-1:0] REG_DMA_WRITE   = 5'd3;
  localparam logic [REG_W-1:0] REG_STATUS      = 5'd4;
  localparam logic [REG_W-1:0] REG_LIST_START  = 5'd8;
  localparam logic [REG_W-1:0] REG_LIST_END    = 5'd9;
  localparam logic [REG_W-1:0] REG_DISP_STATUS = 5'd11;

  // one bus access
  typedef struct packed {
    logic              action;
    logic [REG_W-1:0]  reg_index;
    logic [DATA_W-1:0] write_data;
  } cdr_in_t;

  // one result word
  typedef struct packed {
    logic                read_data;
    logic                dma_start;
    logic                dma_to_remote;
    logic [LOCAL_W-1:0]  dma_local_addr;
    logic [REMOTE_W-1:0] dma_remote_addr;
    logic [LEN_W-1:0]    dma_row_length;
    logic [ROWS_W-1:0]   dma_rows;
    logic [SKIP_W-1:0]   dma_skip;
    logic                wake_core;
    logic                irq_clear;
    logic                irq_set;
    logic                display_kick;
  } cdr_out_t;

endpackage

// ===== design/cdr_if.sv =====
// ----------------------------------------------------------------------------
// cdr channel interfaces
// Valid/ready channels for bus accesses in and result words out.
// ----------------------------------------------------------------------------
interface cdr_in_if;
  logic            valid;
  logic            ready;
  cdr_pkg::cdr_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cdr_out_if;
  logic             valid;
  logic             ready;
  cdr_pkg::cdr_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/coproc_control_dma_registers.sv =====
// ----------------------------------------------------------------------------
// coproc_control_dma_registers
// Control registers of a signal coprocessor: DMA address and trigger
// registers, core status, semaphore and display list registers.
// ----------------------------------------------------------------------------
//
//   channel  dir  payload
//   req      in   action, reg_index, write_data
//   rsp      out  read_data, dma_* descriptor, wake_core, irq_*, display_kick
//
// One access per cycle while rsp is not stalled: an access is held in the input
// register, is decoded against the register state and lands in the result
// register, which drives rsp.valid.
// The longest path is the DMA address advance: a 13x9 multiply and an add.
// Synchronous reset clears both valid flags and loads the reset values; a
// stalled rsp holds the input register, req stalls only with both stages full.
// ----------------------------------------------------------------------------
module coproc_control_dma_registers (
  input logic        clk,
  input logic        rst,
  cdr_in_if.sink     req,
  cdr_out_if.source  rsp
);

  // register state
  logic [cdr_pkg::LOCAL_W-1:0]  local_address;
  logic [cdr_pkg::REMOTE_W-1:0] remote_address;
  logic [cdr_pkg::STATUS_W-1:0] core_status;
  logic                         semaphore_flag;
  logic [cdr_pkg::DATA_W-1:0]   list_start;
  logic [cdr_pkg::DATA_W-1:0]   list_current;
  logic [cdr_pkg::DATA_W-1:0]   list_end;
  logic [cdr_pkg::DISP_W-1:0]   display_status;

  logic [cdr_pkg::LOCAL_W-1:0]  local_address_next;
  logic [cdr_pkg::REMOTE_W-1:0] remote_address_next;
  logic [cdr_pkg::STATUS_W-1:0] core_status_next;
  logic [cdr_pkg::DISP_W-1:0]   display_status_next;

  // pipeline registers
  logic               acc_valid;
  cdr_pkg::cdr_in_t   acc;
  logic               out_valid;
  cdr_pkg::cdr_out_t  out_word;
  cdr_pkg::cdr_out_t  out_word_next;

  logic acc_move;
  logic is_write;

  // dma decode
  logic [cdr_pkg::DATA_W-1:0]   wdata;
  logic [cdr_pkg::SKIP_W-1:0]   dma_skip;
  logic [cdr_pkg::ROWS_W-1:0]   dma_rows;
  logic [cdr_pkg::LEN_W-1:0]    len_raw;
  logic [cdr_pkg::LEN_W-1:0]    room;
  logic [cdr_pkg::LEN_W-1:0]    dma_len;
  logic [cdr_pkg::LEN_W-1:0]    remote_span;
  logic [cdr_pkg::LOCAL_W-1:0]  local_start;
  logic [cdr_pkg::REMOTE_W-1:0] remote_start;
  logic [cdr_pkg::PROD_W-1:0]   local_prod;
  logic [cdr_pkg::PROD_W-1:0]   remote_prod;

  // handshake: the access moves on when the result slot is free or drains
  assign acc_move  = acc_valid && (!out_valid || rsp.ready);
  assign req.ready = !acc_valid || acc_move;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_word;
  assign is_write  = (acc.action == cdr_pkg::ACT_WRITE);
  assign wdata     = acc.write_data;

  // dma descriptor fields
  always_comb begin
    dma_skip     = {wdata[31:23], 3'b000};
    dma_rows     = {1'b0, wdata[19:12]} + cdr_pkg::ROWS_W'(1);
    len_raw      = {1'b0, wdata[11:3], 3'b000} + cdr_pkg::DMA_MIN_LEN;
    room         = cdr_pkg::BANK_SIZE - {1'b0, local_address[11:3], 3'b000};
    dma_len      = (len_raw > room) ? room : len_raw;
    remote_span  = dma_len + {1'b0, dma_skip};
    local_start  = {local_address[12:3], 3'b000};
    remote_start = {1'b0, remote_address[22:3], 3'b000};
    local_prod   = {{cdr_pkg::ROWS_W{1'b0}}, dma_len}
                   * {{cdr_pkg::LEN_W{1'b0}}, dma_rows};
    remote_prod  = {{cdr_pkg::ROWS_W{1'b0}}, remote_span}
                   * {{cdr_pkg::LEN_W{1'b0}}, dma_rows};
  end

  // status register updates: bit 0 halt, bit 1 cleared only, 5..14 pairs
  always_comb begin
    core_status_next        = core_status;
    core_status_next[0]     = (core_status[0] & ~wdata[0]) | wdata[1];
    core_status_next[1]     = core_status[1] & ~wdata[2];
    core_status_next[14:5]  = (core_status[14:5] & ~wdata[14:5]) | wdata[15:6];
    display_status_next     = display_status;
    display_status_next[2:0] = (display_status[2:0] & ~wdata[2:0]) | wdata[3:1];
  end

  // result word and address advance
  always_comb begin
    out_word_next       = '0;
    local_address_next  = local_address;
    remote_address_next = remote_address;
    if (!is_write) begin
      out_word_next.read_data = semaphore_flag;
    end else begin
      case (acc.reg_index)
        cdr_pkg::REG_LOCAL_ADDR: begin
          local_address_next = wdata[cdr_pkg::LOCAL_W-1:0];
        end
        cdr_pkg::REG_REMOTE_ADDR: begin
          remote_address_next = wdata[cdr_pkg::REMOTE_W-1:0];
        end
        cdr_pkg::REG_DMA_READ, cdr_pkg::REG_DMA_WRITE: begin
          out_word_next.dma_start       = 1'b1;
          out_word_next.dma_to_remote   = (acc.reg_index == cdr_pkg::REG_DMA_WRITE);
          out_word_next.dma_local_addr  = local_start;
          out_word_next.dma_remote_addr = remote_start;
          out_word_next.dma_row_length  = dma_len;
          out_word_next.dma_rows        = dma_rows;
          out_word_next.dma_skip        = dma_skip;
          local_address_next  = local_start + local_prod[cdr_pkg::LOCAL_W-1:0];
          remote_address_next = remote_start
                                + {{(cdr_pkg::REMOTE_W-cdr_pkg::PROD_W){1'b0}}, remote_prod};
        end
        cdr_pkg::REG_STATUS: begin
          out_word_next.wake_core = core_status[0] & wdata[0];
          out_word_next.irq_clear = wdata[3];
          out_word_next.irq_set   = wdata[4];
        end
        cdr_pkg::REG_LIST_END: begin
          out_word_next.display_kick = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_valid <= 1'b0;
    end else if (req.ready) begin
      acc_valid <= req.valid;
    end
    if (req.ready && req.valid) begin
      acc <= req.data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (acc_move) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (acc_move) begin
      out_word <= out_word_next;
    end
  end

  // register state update
  always_ff @(posedge clk) begin
    if (rst) begin
      local_address  <= '0;
      remote_address <= '0;
      core_status    <= cdr_pkg::STATUS_RESET;
      semaphore_flag <= 1'b0;
      list_start     <= '0;
      list_current   <= '0;
      list_end       <= '0;
      display_status <= cdr_pkg::DISP_RESET;
    end else if (acc_move) begin
      local_address  <= local_address_next;
      remote_address <= remote_address_next;
      if (!is_write) begin
        semaphore_flag <= 1'b1;
      end else begin
        case (acc.reg_index)
          cdr_pkg::REG_STATUS: begin
            core_status <= core_status_next;
          end
          cdr_pkg::REG_LIST_START: begin
            list_start   <= wdata;
            list_current <= wdata;
          end
          cdr_pkg::REG_LIST_END: begin
            list_end <= wdata;
          end
          cdr_pkg::REG_DISP_STATUS: begin
            display_status <= display_status_next;
          end
          default: begin
          end
        endcase
      end
    end
  end

`ifndef SYNTH
  // once taken, the semaphore stays held
  a_sem_sticky: assert property (@(posedge clk) disable iff (rst)
    semaphore_flag |=> semaphore_flag)
    else $error("semaphore released without reset");

  // a semaphore read carries no write side effects
  a_read_only: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.read_data) |->
      (!out_word.dma_start && !out_word.display_kick && !out_word.wake_core))
    else $error("semaphore read reported a write effect");

  // a descriptor row never runs past the end of the local bank
  a_bank_clamp: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_word.dma_start) |->
      (({1'b0, out_word.dma_local_addr[11:0]} + out_word.dma_row_length)
        <= cdr_pkg::BANK_SIZE) && (out_word.dma_row_length != '0))
    else $error("dma row length exceeds the local bank");

  // advancing after a descriptor keeps the local address word aligned
  a_local_align: assert property (@(posedge clk) disable iff (rst)
    (acc_move && out_word_next.dma_start) |=> (local_address[2:0] == 3'b000))
    else $error("local address misaligned after dma");

  // result register only loads when an access moves over
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (!out_valid && !acc_valid) |=> !out_valid)
    else $error("result appeared without an access");
`endif

endmodule
